### design/sitda_pkg.sv
// Shared constants and stage type for the signed integer to decimal ASCII converter.
`default_nettype none

package sitda_pkg;

   // Input word width and derived sizes
   localparam int VALUE_WIDTH      = 32;
   localparam int STEPS_PER_STAGE  = 8;
   localparam int DABBLE_STAGES    = (VALUE_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int PAD_WIDTH        = DABBLE_STAGES * STEPS_PER_STAGE;
   // Upper bound on decimal digits of a VALUE_WIDTH-bit magnitude (1233/4096 ~ log10(2))
   localparam int NUM_DIGITS       = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int BCD_WIDTH        = NUM_DIGITS * 4;
   localparam int DIGIT_IDX_WIDTH  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int CHAR_COUNT_WIDTH = 4;

   // Character codes
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;

   // Double-dabble correction: a digit of five or more gets three added before the shift
   localparam logic [3:0] DABBLE_LIMIT = 4'd5;
   localparam logic [3:0] DABBLE_BIAS  = 4'd3;

   // One conversion stage: remaining binary bits shift into the BCD digits
   typedef struct packed {
      logic                   valid;
      logic                   negative;
      logic [PAD_WIDTH-1:0]   bin;
      logic [BCD_WIDTH-1:0]   bcd;
   } stage_type;

endpackage

`default_nettype wire

### design/sitda_dabble_stage.sv
// One registered stage of the pipelined binary to BCD conversion.
`default_nettype none

module sitda_dabble_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire sitda_pkg::stage_type stage_in,
   output      sitda_pkg::stage_type stage_out
);
   import sitda_pkg::*;

   stage_type               stage_ff;
   stage_type               stage_in_next;
   logic [BCD_WIDTH-1:0]    bcd_work;
   logic [PAD_WIDTH-1:0]    bin_work;

   // Run a fixed group of add-three and shift steps
   always_comb begin
      bcd_work = stage_in.bcd;
      bin_work = stage_in.bin;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_work[d*4 +: 4] >= DABBLE_LIMIT) begin
               bcd_work[d*4 +: 4] = bcd_work[d*4 +: 4] + DABBLE_BIAS;
            end
         end
         bcd_work = {bcd_work[BCD_WIDTH-2:0], bin_work[PAD_WIDTH-1]};
         bin_work = {bin_work[PAD_WIDTH-2:0], 1'b0};
      end
      stage_in_next          = stage_in;
      stage_in_next.bcd      = bcd_work;
      stage_in_next.bin      = bin_work;
   end

   // Advance the stage; hold on stall, drop valid on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

### design/sitda_emit.sv
// Character serializer: counts digits and sends one ASCII character per cycle.
`default_nettype none

module sitda_emit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire sitda_pkg::stage_type                   pipe,
   output      logic                                   advance,
   output      logic                                   rsp_valid,
   output      logic [7:0]                             rsp_char_code,
   output      logic                                   rsp_last,
   output      logic [sitda_pkg::CHAR_COUNT_WIDTH-1:0] rsp_char_count
);
   import sitda_pkg::*;

   logic                          active_ff,  active_in;
   logic                          sign_ff,    sign_in;
   logic [DIGIT_IDX_WIDTH-1:0]    pos_ff,     pos_in;
   logic [CHAR_COUNT_WIDTH-1:0]   total_ff,   total_in;
   logic [BCD_WIDTH-1:0]          bcd_ff,     bcd_in;

   logic                          rsp_valid_ff,  rsp_valid_in;
   logic [7:0]                    rsp_code_ff,   rsp_code_in;
   logic                          rsp_last_ff,   rsp_last_in;
   logic [CHAR_COUNT_WIDTH-1:0]   rsp_count_ff,  rsp_count_in;

   logic [DIGIT_IDX_WIDTH-1:0]    top_idx;
   logic [CHAR_COUNT_WIDTH-1:0]   total_calc;
   logic                          finishing;
   logic                          load;
   logic [3:0]                    cur_digit;

   // Find the most significant nonzero digit; zero still prints one digit
   always_comb begin
      top_idx = '0;
      for (int d = 1; d < NUM_DIGITS; d++) begin
         if (pipe.bcd[d*4 +: 4] != 4'd0) begin
            top_idx = DIGIT_IDX_WIDTH'(d);
         end
      end
      total_calc = CHAR_COUNT_WIDTH'(top_idx) + CHAR_COUNT_WIDTH'(1)
                 + CHAR_COUNT_WIDTH'(pipe.negative);
   end

   // Load a new word when idle or on the final character of the current one
   always_comb begin
      finishing = active_ff && !sign_ff && (pos_ff == '0);
      load      = pipe.valid && (!active_ff || finishing);
      advance   = !pipe.valid || load;
      cur_digit = bcd_ff[pos_ff*4 +: 4];
   end

   // Next serializer state
   always_comb begin
      active_in = active_ff;
      sign_in   = sign_ff;
      pos_in    = pos_ff;
      total_in  = total_ff;
      bcd_in    = bcd_ff;
      if (load) begin
         active_in = 1'b1;
         sign_in   = pipe.negative;
         pos_in    = top_idx;
         total_in  = total_calc;
         bcd_in    = pipe.bcd;
      end else if (finishing) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            pos_in = pos_ff - 1'b1;
         end
      end
   end

   // Output word for this cycle
   always_comb begin
      rsp_valid_in = active_ff;
      rsp_code_in  = sign_ff ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, cur_digit});
      rsp_last_in  = finishing;
      rsp_count_in = finishing ? total_ff : '0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sign_ff      <= sign_in;
      pos_ff       <= pos_in;
      total_ff     <= total_in;
      bcd_ff       <= bcd_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_code  = rsp_code_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_char_count = rsp_count_ff;

endmodule

`default_nettype wire

### design/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII converter.
// Usage:
//   Drive req_value and raise start; the word is taken at a clock edge where
//   start is high and busy is low. The value is two's complement, sign in the
//   top bit; the most negative value prints its full magnitude.
//   Characters leave one per cycle on rsp_char_code with rsp_valid high for
//   that single cycle: an optional minus sign, then digits most significant
//   first, no leading zeros. rsp_last marks the final character, where
//   rsp_char_count carries the run length; elsewhere it reads zero.
// Pipeline: the accepted word passes the sign stage, four add-three/shift
//   stages of eight steps each, then the serializer and its output register
//   before the first character appears.
// Flow: a run of N characters (1 to 11) occupies the serializer, which loads
//   the next word on the final character of the current run; while the last
//   stage waits on the serializer the whole pipeline holds and busy is high.
// Reset: synchronous, active high; clears all valid bits and the serializer,
//   drops busy and any run in progress.
// The receiver cannot stall: every character is taken in its cycle.
`default_nettype none

module signed_int_to_decimal_ascii (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output      logic                                   busy,
   input  wire logic signed [sitda_pkg::VALUE_WIDTH-1:0] req_value,
   output      logic                                   rsp_valid,
   output      logic [7:0]                             rsp_char_code,
   output      logic                                   rsp_last,
   output      logic [sitda_pkg::CHAR_COUNT_WIDTH-1:0] rsp_char_count
);
   import sitda_pkg::*;

   stage_type                s0_ff, s0_in;
   stage_type                chain [DABBLE_STAGES+1];
   logic                     advance;
   logic                     accept;
   logic                     negative;
   logic [VALUE_WIDTH-1:0]   magnitude;

   // Take the sign and the unsigned magnitude of the incoming word
   always_comb begin
      accept         = start && advance;
      negative       = req_value[VALUE_WIDTH-1];
      magnitude      = negative ? (~$unsigned(req_value) + 1'b1) : $unsigned(req_value);
      s0_in.valid    = accept;
      s0_in.negative = negative;
      s0_in.bin      = PAD_WIDTH'(magnitude);
      s0_in.bcd      = '0;
   end

   // Sign stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (advance) begin
         s0_ff <= s0_in;
      end
   end

   assign chain[0] = s0_ff;

   // Conversion pipeline
   for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
      sitda_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   // Serializer
   sitda_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .pipe           (chain[DABBLE_STAGES]),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_char_code  (rsp_char_code),
      .rsp_last       (rsp_last),
      .rsp_char_count (rsp_char_count)
   );

   assign busy = !advance;

endmodule

`default_nettype wire
